FILE: rtl/core/flr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flr_pkg
// Shared types and constants of the framed link receiver.
// ----------------------------------------------------------------------------
package flr_pkg;

  localparam int MAX_PAYLOAD = 4096;
  localparam int CNT_W       = 13;
  localparam int IDX_W       = 3;

  localparam logic [IDX_W-1:0] CFG_FLAG   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_ESCAPE = 3'd1;
  localparam logic [IDX_W-1:0] CFG_ADDR   = 3'd2;
  localparam logic [IDX_W-1:0] CFG_CTRL0  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_CTRL1  = 3'd4;
  localparam logic [IDX_W-1:0] CFG_DISC   = 3'd5;

  typedef enum logic [1:0] {
    EV_DATA = 2'd0,
    EV_GOOD = 2'd1,
    EV_BAD  = 2'd2,
    EV_DISC = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] escape_byte;
    logic [7:0] address_byte;
    logic [7:0] info_ctrl_zero;
    logic [7:0] info_ctrl_one;
    logic [7:0] disc_ctrl;
  } cfg_t;

  typedef struct packed {
    event_kind_t      kind;
    logic [7:0]       data;
    logic             seq;
    logic [CNT_W-1:0] len;
    logic             last;
  } result_t;

  // Up to two results caused by one received word.
  typedef struct packed {
    result_t    r0;
    result_t    r1;
    logic [1:0] n;
  } res_pair_t;

endpackage
`default_nettype wire

FILE: rtl/core/flr_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flr_cfg_regs
// Configuration register file: flag, escape, address and control codes.
// ----------------------------------------------------------------------------
module flr_cfg_regs import flr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [7:0]       cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_byte      <= 8'd126;
      cfg_r.escape_byte    <= 8'd125;
      cfg_r.address_byte   <= 8'd3;
      cfg_r.info_ctrl_zero <= 8'd0;
      cfg_r.info_ctrl_one  <= 8'd64;
      cfg_r.disc_ctrl      <= 8'd11;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FLAG:   cfg_r.flag_byte      <= cfg_data;
        CFG_ESCAPE: cfg_r.escape_byte    <= cfg_data;
        CFG_ADDR:   cfg_r.address_byte   <= cfg_data;
        CFG_CTRL0:  cfg_r.info_ctrl_zero <= cfg_data;
        CFG_CTRL1:  cfg_r.info_ctrl_one  <= cfg_data;
        CFG_DISC:   cfg_r.disc_ctrl      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/flr_frame_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flr_frame_fsm
// Header hunt, destuffing, one-word delay and frame check for each word.
// ----------------------------------------------------------------------------
module flr_frame_fsm import flr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       fire,
  input  wire logic [7:0] rx_byte,
  output res_pair_t       res
);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_AFTER_FLAG,
    ST_AFTER_ADDR,
    ST_AFTER_CTRL,
    ST_DATA,
    ST_ESCAPED
  } state_t;

  typedef struct packed {
    logic [7:0]       held;
    logic             held_valid;
    logic [7:0]       xor_acc;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } dp_t;

  typedef struct packed {
    dp_t        dp;
    logic       emit;
    logic [7:0] data;
  } take_t;

  localparam dp_t DP_CLEAR = '0;

  state_t     state_r, state_nxt;
  dp_t        dp_r, dp_nxt;
  logic       seq_r, seq_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;

  function automatic take_t take_word(dp_t d, logic [7:0] b);
    take_t t;
    t.dp   = d;
    t.emit = 1'b0;
    t.data = d.held;
    if (d.held_valid) begin
      if (d.count < CNT_W'(MAX_PAYLOAD)) begin
        t.emit       = 1'b1;
        t.dp.xor_acc = d.xor_acc ^ d.held;
        t.dp.count   = d.count + 1'b1;
      end else begin
        t.dp.overflow = 1'b1;
      end
    end
    t.dp.held       = b;
    t.dp.held_valid = 1'b1;
    return t;
  endfunction

  function automatic result_t data_result(logic [7:0] b);
    result_t r;
    r      = '0;
    r.kind = EV_DATA;
    r.data = b;
    return r;
  endfunction

  always_comb begin
    take_t t1;
    take_t t2;
    logic  good;
    state_nxt = state_r;
    dp_nxt    = dp_r;
    seq_nxt   = seq_r;
    ctrl_nxt  = ctrl_r;
    res       = '0;
    t1        = take_word(dp_r, rx_byte);
    t2        = take_word(t1.dp, rx_byte);
    good      = dp_r.held_valid && (dp_r.count != '0) && !dp_r.overflow &&
                (dp_r.held == dp_r.xor_acc);
    case (state_r)
      ST_HUNT: begin
        if (rx_byte == cfg.flag_byte) state_nxt = ST_AFTER_FLAG;
      end
      ST_AFTER_FLAG: begin
        if (rx_byte == cfg.address_byte) state_nxt = ST_AFTER_ADDR;
        else if (rx_byte != cfg.flag_byte) state_nxt = ST_HUNT;
      end
      ST_AFTER_ADDR: begin
        if (rx_byte == cfg.info_ctrl_zero || rx_byte == cfg.info_ctrl_one) begin
          ctrl_nxt  = rx_byte;
          state_nxt = ST_AFTER_CTRL;
        end else if (rx_byte == cfg.flag_byte) begin
          state_nxt = ST_AFTER_FLAG;
        end else if (rx_byte == cfg.disc_ctrl) begin
          res.r0.kind = EV_DISC;
          res.n       = 2'd1;
          state_nxt   = ST_HUNT;
        end else begin
          state_nxt = ST_HUNT;
        end
      end
      ST_AFTER_CTRL: begin
        if (rx_byte == (cfg.address_byte ^ ctrl_r)) begin
          dp_nxt    = DP_CLEAR;
          state_nxt = ST_DATA;
        end else if (rx_byte == cfg.flag_byte) begin
          state_nxt = ST_AFTER_FLAG;
        end else begin
          state_nxt = ST_HUNT;
        end
      end
      ST_DATA: begin
        if (rx_byte == cfg.escape_byte) begin
          state_nxt = ST_ESCAPED;
        end else if (rx_byte == cfg.flag_byte) begin
          res.r0.kind = good ? EV_GOOD : EV_BAD;
          res.r0.seq  = seq_r;
          res.r0.len  = dp_r.count;
          res.n       = 2'd1;
          if (good) seq_nxt = ~seq_r;
          dp_nxt    = DP_CLEAR;
          state_nxt = ST_HUNT;
        end else begin
          dp_nxt = t1.dp;
          if (t1.emit) begin
            res.r0 = data_result(t1.data);
            res.n  = 2'd1;
          end
        end
      end
      ST_ESCAPED: begin
        state_nxt = ST_DATA;
        if (rx_byte == cfg.escape_byte || rx_byte == cfg.flag_byte) begin
          dp_nxt = t1.dp;
          if (t1.emit) begin
            res.r0 = data_result(t1.data);
            res.n  = 2'd1;
          end
        end else begin
          // escape word itself goes in first, then the received word
          t1     = take_word(dp_r, cfg.escape_byte);
          t2     = take_word(t1.dp, rx_byte);
          dp_nxt = t2.dp;
          if (t1.emit) begin
            res.r0 = data_result(t1.data);
            if (t2.emit) begin
              res.r1 = data_result(t2.data);
              res.n  = 2'd2;
            end else begin
              res.n = 2'd1;
            end
          end else if (t2.emit) begin
            res.r0 = data_result(t2.data);
            res.n  = 2'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
    if (res.n == 2'd1) res.r0.last = 1'b1;
    if (res.n == 2'd2) res.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      dp_r    <= DP_CLEAR;
      seq_r   <= 1'b1;
      ctrl_r  <= 8'd0;
    end else if (fire) begin
      state_r <= state_nxt;
      dp_r    <= dp_nxt;
      seq_r   <= seq_nxt;
      ctrl_r  <= ctrl_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/flr_result_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flr_result_fifo
// Four-entry result queue: takes up to two results a cycle, sends one while out_stall is low.
// ----------------------------------------------------------------------------
module flr_result_fifo import flr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire res_pair_t pair,
  output logic           room,
  output logic           out_valid,
  input  wire logic      out_stall,
  output result_t        head
);

  result_t    mem_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;
  logic [1:0] push_n;
  logic       pop;

  assign push_n    = push ? pair.n : 2'd0;
  assign out_valid = (count_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  // room for two more even without a pop this cycle
  assign room      = (count_r <= 3'd2);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_ptr_r] <= pair.r0;
    if (push_n == 2'd2) mem_r[wr_ptr_r + 2'd1] <= pair.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n;
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      count_r <= 3'(count_r + {1'b0, push_n} - {2'b00, pop});
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/framed_link_receiver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// framed_link_receiver_top
// Byte-stuffed framed link receiver: header hunt, destuffing, frame check.
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// in_      input      in_valid/in_stall  in_rx_byte
// out_     output     out_valid/out_stall  event_kind, data_byte, reply_seq,
//                                          frame_length, last
// cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One received word is taken per cycle while in_stall is low; its results
// go into a four-entry result queue, sent one result word per cycle while
// out_stall is low. in_stall rises while the queue holds three or more
// results; a word that yields two results is sent as two result words.
// Reset (rst_n low, synchronous) restores the register defaults, hunting
// state and reply sequence one; no clearing pass follows.
// ----------------------------------------------------------------------------
module framed_link_receiver_top import flr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_rx_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_event_kind,
  output logic [7:0]            out_data_byte,
  output logic                  out_reply_seq,
  output logic [CNT_W-1:0]      out_frame_length,
  output logic                  out_last,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [7:0]       cfg_data
);

  cfg_t      cfg;
  res_pair_t pair;
  result_t   head;
  logic      room;
  logic      in_fire;

  assign in_stall = !room;
  assign in_fire  = in_valid && room;

  flr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  flr_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fire    (in_fire),
    .rx_byte (in_rx_byte),
    .res     (pair)
  );

  flr_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .pair      (pair),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_event_kind   = head.kind;
  assign out_data_byte    = head.data;
  assign out_reply_seq    = head.seq;
  assign out_frame_length = head.len;
  assign out_last         = head.last;

endmodule
`default_nettype wire

FILE: sim/tb_framed_link_receiver_top.sv
// ----------------------------------------------------------------------------
// tb_framed_link_receiver_top
// Self-checking bench for the framed link receiver. Frames are built with
// random content, random header, check and stuffing faults, noise and empty frames.
// Each received word is decoded by
// a bench-side frame decoder, and its events are compared field by field
// with the block's result words. The block is run under several register
// settings and with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_framed_link_receiver_top;
  import flr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    LS_HUNT, LS_AFTER_FLAG, LS_AFTER_ADDR, LS_AFTER_CTRL, LS_DATA, LS_ESCAPED
  } link_state_t;

  typedef enum int {
    FF_NONE, FF_BAD_CHECK, FF_NO_BYTES, FF_HDR_FLAG, FF_BAD_ADDR, FF_BAD_CTRL,
    FF_BAD_HCS, FF_DISC, FF_ESC_PAIR
  } frame_fault_t;

  typedef logic [7:0] byte_q_t[$];

  localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam cfg_t CFG_DEFAULT = '{flag_byte: 8'h7E, escape_byte: 8'h7D,
                                   address_byte: 8'h03, info_ctrl_zero: 8'h00,
                                   info_ctrl_one: 8'h40, disc_ctrl: 8'h0B};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_event_kind;
  logic [7:0]       out_data_byte;
  logic             out_reply_seq;
  logic [CNT_W-1:0] out_frame_length;
  logic             out_last;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [7:0]       cfg_data = 8'h00;

  framed_link_receiver_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_data_byte    (out_data_byte),
    .out_reply_seq    (out_reply_seq),
    .out_frame_length (out_frame_length),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  logic [7:0] line_bytes[$];
  result_t    expected_events[$];
  int         errors = 0;
  bit         idle_on = 1'b0;
  cfg_t       line_cfg = CFG_DEFAULT;

  // decoder state, tracks the block
  cfg_t        rx_cfg;
  link_state_t rx_state;
  logic [7:0]  rx_held;
  logic        rx_held_v;
  logic [7:0]  rx_xor;
  int          rx_count;
  logic        rx_ovf;
  logic        rx_seq;
  logic [7:0]  rx_ctrl;
  int          step_events;

  function automatic cfg_t with_reg(cfg_t c, logic [IDX_W-1:0] idx, logic [7:0] v);
    case (idx)
      CFG_FLAG:   c.flag_byte = v;
      CFG_ESCAPE: c.escape_byte = v;
      CFG_ADDR:   c.address_byte = v;
      CFG_CTRL0:  c.info_ctrl_zero = v;
      CFG_CTRL1:  c.info_ctrl_one = v;
      CFG_DISC:   c.disc_ctrl = v;
      default: ;
    endcase
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_event(event_kind_t k, logic [7:0] d, logic s, logic [CNT_W-1:0] len);
    result_t r;
    r.kind = k;
    r.data = d;
    r.seq  = s;
    r.len  = len;
    r.last = 1'b0;
    expected_events.push_back(r);
    step_events++;
  endtask

  task automatic clear_frame();
    rx_held   = 8'h00;
    rx_held_v = 1'b0;
    rx_xor    = 8'h00;
    rx_count  = 0;
    rx_ovf    = 1'b0;
  endtask

  // one-byte delay: the previous destuffed byte goes out when a new one comes
  task automatic shift_in(logic [7:0] b);
    if (rx_held_v) begin
      if (rx_count < MAX_PAYLOAD) begin
        push_event(EV_DATA, rx_held, 1'b0, '0);
        rx_xor ^= rx_held;
        rx_count++;
      end else begin
        rx_ovf = 1'b1;
      end
    end
    rx_held   = b;
    rx_held_v = 1'b1;
  endtask

  task automatic decode_rx_word(logic [7:0] b);
    bit good;
    step_events = 0;
    case (rx_state)
      LS_HUNT: begin
        if (b == rx_cfg.flag_byte) rx_state = LS_AFTER_FLAG;
      end
      LS_AFTER_FLAG: begin
        if (b == rx_cfg.address_byte) rx_state = LS_AFTER_ADDR;
        else if (b != rx_cfg.flag_byte) rx_state = LS_HUNT;
      end
      LS_AFTER_ADDR: begin
        if (b == rx_cfg.info_ctrl_zero || b == rx_cfg.info_ctrl_one) begin
          rx_ctrl  = b;
          rx_state = LS_AFTER_CTRL;
        end else if (b == rx_cfg.flag_byte) begin
          rx_state = LS_AFTER_FLAG;
        end else if (b == rx_cfg.disc_ctrl) begin
          push_event(EV_DISC, 8'h00, 1'b0, '0);
          rx_state = LS_HUNT;
        end else begin
          rx_state = LS_HUNT;
        end
      end
      LS_AFTER_CTRL: begin
        if (b == (rx_cfg.address_byte ^ rx_ctrl)) begin
          clear_frame();
          rx_state = LS_DATA;
        end else if (b == rx_cfg.flag_byte) begin
          rx_state = LS_AFTER_FLAG;
        end else begin
          rx_state = LS_HUNT;
        end
      end
      LS_DATA: begin
        if (b == rx_cfg.escape_byte) begin
          rx_state = LS_ESCAPED;
        end else if (b == rx_cfg.flag_byte) begin
          good = rx_held_v && rx_count > 0 && !rx_ovf && rx_held == rx_xor;
          push_event(good ? EV_GOOD : EV_BAD, 8'h00, rx_seq, rx_count[CNT_W-1:0]);
          if (good) rx_seq = ~rx_seq;
          clear_frame();
          rx_state = LS_HUNT;
        end else begin
          shift_in(b);
        end
      end
      LS_ESCAPED: begin
        rx_state = LS_DATA;
        if (b == rx_cfg.escape_byte || b == rx_cfg.flag_byte) begin
          shift_in(b);
        end else begin
          shift_in(rx_cfg.escape_byte);
          shift_in(b);
        end
      end
      default: rx_state = LS_HUNT;
    endcase
    if (step_events > 0) expected_events[expected_events.size() - 1].last = 1'b1;
  endtask

  // driver: input words and decoder update
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      rx_cfg   = CFG_DEFAULT;
      rx_state = LS_HUNT;
      rx_seq   = 1'b1;
      rx_ctrl  = 8'h00;
      clear_frame();
    end else begin
      if (cfg_valid && cfg_ready) rx_cfg = with_reg(rx_cfg, cfg_index, cfg_data);
      if (in_valid && !in_stall) decode_rx_word(in_rx_byte);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (line_bytes.size() > 0) begin
          in_rx_byte <= line_bytes.pop_front();
          in_valid   <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic cmp_field(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_events.size() == 0) begin
      $display("%0t: result word with none expected, actual kind %0d data %0h len %0d",
               $time, out_event_kind, out_data_byte, out_frame_length);
      errors++;
    end else begin
      want = expected_events.pop_front();
      cmp_field("event_kind", CNT_W'(want.kind), CNT_W'(out_event_kind));
      cmp_field("data_byte", CNT_W'(want.data), CNT_W'(out_data_byte));
      cmp_field("reply_seq", CNT_W'(want.seq), CNT_W'(out_reply_seq));
      cmp_field("frame_length", want.len, out_frame_length);
      cmp_field("last", CNT_W'(want.last), CNT_W'(out_last));
    end
  endtask

  // monitor: result words and output stall
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  int quiet;
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet = 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    line_cfg = with_reg(line_cfg, idx, v);
  endtask

  task automatic write_cfg(cfg_t c);
    write_reg(CFG_FLAG, c.flag_byte);
    write_reg(CFG_ESCAPE, c.escape_byte);
    write_reg(CFG_ADDR, c.address_byte);
    write_reg(CFG_CTRL0, c.info_ctrl_zero);
    write_reg(CFG_CTRL1, c.info_ctrl_one);
    write_reg(CFG_DISC, c.disc_ctrl);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (line_bytes.size() > 0 || in_valid || expected_events.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_stuffed(logic [7:0] d);
    if (d == line_cfg.flag_byte || d == line_cfg.escape_byte)
      line_bytes.push_back(line_cfg.escape_byte);
    line_bytes.push_back(d);
  endtask

  task automatic send_frame(byte_q_t payload, frame_fault_t fault);
    logic [7:0] a, ctrl, hcs, chk, odd;
    int k;
    a    = line_cfg.address_byte;
    ctrl = $urandom_range(0, 1) ? line_cfg.info_ctrl_one : line_cfg.info_ctrl_zero;
    hcs  = a ^ ctrl;
    chk  = 8'h00;
    line_bytes.push_back(line_cfg.flag_byte);
    case (fault)
      FF_HDR_FLAG: begin
        k = $urandom_range(0, 2);
        if (k >= 1) line_bytes.push_back(a);
        if (k >= 2) line_bytes.push_back(ctrl);
        line_bytes.push_back(line_cfg.flag_byte);
      end
      FF_BAD_ADDR: begin
        do a = 8'($urandom); while (a == line_cfg.address_byte || a == line_cfg.flag_byte);
      end
      FF_BAD_CTRL: begin
        do ctrl = 8'($urandom);
        while (ctrl == line_cfg.info_ctrl_zero || ctrl == line_cfg.info_ctrl_one ||
               ctrl == line_cfg.flag_byte || ctrl == line_cfg.disc_ctrl);
      end
      FF_BAD_HCS: begin
        do hcs = 8'($urandom); while (hcs == (a ^ ctrl) || hcs == line_cfg.flag_byte);
      end
      FF_DISC: begin
        line_bytes.push_back(a);
        line_bytes.push_back(line_cfg.disc_ctrl);
        return;
      end
      default: ;
    endcase
    line_bytes.push_back(a);
    line_bytes.push_back(ctrl);
    line_bytes.push_back(hcs);
    if (fault == FF_NO_BYTES) begin
      line_bytes.push_back(line_cfg.flag_byte);
      return;
    end
    foreach (payload[i]) begin
      if (fault == FF_ESC_PAIR && i == 0) begin
        // bare escape before an ordinary byte: both pass on as data
        do odd = 8'($urandom);
        while (odd == line_cfg.flag_byte || odd == line_cfg.escape_byte);
        line_bytes.push_back(line_cfg.escape_byte);
        line_bytes.push_back(odd);
        chk ^= line_cfg.escape_byte ^ odd;
      end
      put_stuffed(payload[i]);
      chk ^= payload[i];
    end
    if (fault == FF_BAD_CHECK) chk ^= 8'h01 << $urandom_range(0, 7);
    put_stuffed(chk);
    line_bytes.push_back(line_cfg.flag_byte);
  endtask

  function automatic byte_q_t rand_payload(int n);
    byte_q_t p;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) p.push_back(line_cfg.flag_byte);
      else if (r < 12) p.push_back(line_cfg.escape_byte);
      else if (r < 16) p.push_back(8'h00);
      else if (r < 20) p.push_back(8'hFF);
      else p.push_back(8'($urandom));
    end
    return p;
  endfunction

  function automatic frame_fault_t pick_fault();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return FF_NONE;
    if (r < 65) return FF_BAD_CHECK;
    if (r < 70) return FF_NO_BYTES;
    if (r < 78) return FF_HDR_FLAG;
    if (r < 83) return FF_BAD_ADDR;
    if (r < 88) return FF_BAD_CTRL;
    if (r < 93) return FF_BAD_HCS;
    if (r < 97) return FF_DISC;
    return FF_ESC_PAIR;
  endfunction

  task automatic random_traffic(int n_words);
    int target, len;
    target = line_bytes.size() + n_words;
    while (line_bytes.size() < target) begin
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 6))
          line_bytes.push_back($urandom_range(0, 9) == 0 ? line_cfg.flag_byte :
                               8'($urandom));
      end else begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 64);
        send_frame(rand_payload(len), pick_fault());
      end
    end
  endtask

  initial begin
    byte_q_t p;
    cfg_t c;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values
    p = {8'h00, 8'hFF};
    send_frame(p, FF_NONE);
    line_bytes.push_back(line_cfg.address_byte);
    p = {};
    send_frame(p, FF_NO_BYTES);
    send_frame(p, FF_NONE);
    send_frame(p, FF_DISC);
    p = {line_cfg.flag_byte};
    send_frame(p, FF_ESC_PAIR);
    drain();

    idle_on = 1'b1;
    random_traffic(300);
    drain();

    c = '{flag_byte: 8'h00, escape_byte: 8'hFF, address_byte: 8'hFF,
          info_ctrl_zero: 8'h01, info_ctrl_one: 8'h80, disc_ctrl: 8'hFE};
    write_cfg(c);
    random_traffic(350);
    drain();

    // control one equals the flag: control match wins
    c = '{flag_byte: 8'hFF, escape_byte: 8'h00, address_byte: 8'h00,
          info_ctrl_zero: 8'h00, info_ctrl_one: 8'hFF, disc_ctrl: 8'h7F};
    write_cfg(c);
    idle_on = 1'b0;
    random_traffic(350);
    drain();

    c = cfg_t'(48'({$urandom, $urandom}));
    write_cfg(c);
    idle_on = 1'b1;
    random_traffic(350);
    drain();

    write_cfg(CFG_DEFAULT);
    write_reg(CFG_SPARE_LO, 8'hA5);
    write_reg(CFG_SPARE_HI, 8'h5A);
    random_traffic(300);
    drain();

    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/flr_pkg.sv
rtl/core/flr_cfg_regs.sv
rtl/core/flr_frame_fsm.sv
rtl/core/flr_result_fifo.sv
rtl/core/framed_link_receiver_top.sv
sim/tb_framed_link_receiver_top.sv
